FILE: hw/rtl/mrpt_pkg.sv
// package for the mapped region protection table
// holds codes, fsm state type and controller/datapath command and status structs
`timescale 1ns / 1ps

package mrpt_pkg;

   localparam int MAX_REGIONS_DEF = 16;
   localparam int PAGE_BYTES_DEF  = 4096;
   localparam int ADDR_BITS       = 32;

   localparam logic [31:0] ADDR_MASK = (32'h1 << ADDR_BITS) - 32'h1;

   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 40;

   typedef enum logic [1:0] {
      CMD_MAP     = 2'd0,
      CMD_UNMAP   = 2'd1,
      CMD_PROTECT = 2'd2,
      CMD_CHECK   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_ZERO     = 3'd1,
      STS_LIMIT    = 3'd2,
      STS_OVERLAP  = 3'd3,
      STS_NOREGION = 3'd4,
      STS_FULL     = 3'd5
   } status_type;

   typedef enum logic {
      CSR_REGION_BASE   = 1'b0,
      CSR_ADDRESS_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      RES_ZERO,
      RES_FULL,
      RES_LIMIT,
      RES_OVERLAP,
      RES_MAPOK,
      RES_MISS,
      RES_HIT
   } res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_PAD,
      ST_SUM,
      ST_CMP,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic    load;
      logic    div_step;
      logic    pad;
      logic    sum;
      logic    rd_en;
      logic    idx_inc;
      logic    finish;
      res_type res;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    len_zero;
      logic    full;
      logic    fixed;
      logic    used_zero;
      logic    div_last;
      logic    over;
      logic    hit;
      logic    last;
      logic    rsp_free;
   } sts_type;

endpackage

FILE: hw/rtl/mrpt_ctrl.sv
// controller fsm for the mapped region protection table
// sequences decode, page rounding, limit test and table scan; uses mrpt_pkg
`timescale 1ns / 1ps

module mrpt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  mrpt_pkg::sts_type sts,
   output mrpt_pkg::ctl_type ctl
);
   import mrpt_pkg::*;

   state_type state_ff, state_in;
   res_type   res_ff, res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         res_ff   <= RES_MISS;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      res_in     = res_ff;
      ctl        = '0;
      ctl.res    = res_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.cmd == CMD_MAP) begin
               if (sts.len_zero) begin
                  res_in   = RES_ZERO;
                  state_in = ST_FINISH;
               end else if (sts.full) begin
                  res_in   = RES_FULL;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_DIV;
               end
            end else if (sts.used_zero) begin
               res_in   = RES_MISS;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            if (sts.div_last) state_in = ST_PAD;
         end
         ST_PAD: begin
            ctl.pad  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            ctl.sum  = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (sts.over) begin
               res_in   = RES_LIMIT;
               state_in = ST_FINISH;
            end else if (sts.fixed && !sts.used_zero) begin
               state_in = ST_SCAN_RD;
            end else begin
               res_in   = RES_MAPOK;
               state_in = ST_FINISH;
            end
         end
         ST_SCAN_RD: begin
            ctl.rd_en = 1'b1;
            state_in  = ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            if (sts.hit) begin
               res_in   = (sts.cmd == CMD_MAP) ? RES_OVERLAP : RES_HIT;
               state_in = ST_FINISH;
            end else if (sts.last) begin
               res_in   = (sts.cmd == CMD_MAP) ? RES_MAPOK : RES_MISS;
               state_in = ST_FINISH;
            end else begin
               ctl.idx_inc = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: hw/rtl/mrpt_datapath.sv
// datapath for the mapped region protection table
// item latch, region memories, page remainder unit, scan compare and result register
`timescale 1ns / 1ps

module mrpt_datapath #(
   parameter int MAX_REGIONS = mrpt_pkg::MAX_REGIONS_DEF,
   parameter int PAGE_BYTES  = mrpt_pkg::PAGE_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [mrpt_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic [1:0]                           req_tuser,
   input  logic                                 csr_valid,
   input  logic                                 csr_index,
   input  logic [31:0]                          csr_wdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mrpt_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  mrpt_pkg::ctl_type                    ctl,
   output mrpt_pkg::sts_type                    sts
);
   import mrpt_pkg::*;

   localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int UW = $clog2(MAX_REGIONS + 1);
   localparam int PW = $clog2(PAGE_BYTES) + 1;
   localparam int PL = $clog2(PAGE_BYTES);
   // ceil(2^(32+PL) / PAGE_BYTES): exact quotient for any 32-bit length
   localparam logic [63:0] RecipW = ((64'd1 << (32 + PL)) + 64'(PAGE_BYTES) - 64'd1)
                                    / 64'(PAGE_BYTES);
   localparam logic [32:0]   Recip   = RecipW[32:0];
   localparam logic [32:0]   PageA   = 33'(PAGE_BYTES);
   localparam logic [UW-1:0] MaxUsed = UW'(MAX_REGIONS);

   // configuration and table state
   logic [31:0]   limit_ff, bump_ff;
   logic [UW-1:0] used_ff;
   logic [MAX_REGIONS-1:0] act_ff;
   logic [31:0]   start_mem [MAX_REGIONS];
   logic [31:0]   len_mem   [MAX_REGIONS];
   logic [2:0]    prot_mem  [MAX_REGIONS];

   // item latch
   cmd_type     cmd_ff;
   logic [31:0] addr_ff, len_ff;
   logic [2:0]  prot_ff;
   logic        fixed_ff, wr_ff;

   // working registers
   logic [PW-1:0] rem_ff;
   logic          div_ph_ff;
   logic [31:0]   quot_ff;
   logic [32:0]   alen_ff;
   logic [33:0]   sum_ff;
   logic [IW-1:0] idx_ff;
   logic [31:0]   rd_s_ff, rd_l_ff;
   logic [2:0]    rd_p_ff;

   logic          rsp_valid_ff;
   status_type    rsp_status_ff;
   logic [31:0]   rsp_start_ff;
   logic          rsp_inreg_ff, rsp_allow_ff;

   logic [64:0]   prod;
   logic [63:0]   qp;
   logic [32:0]   pad, rd_end;
   logic [31:0]   start_w;
   logic [IW-1:0] app_idx;
   logic          hit_raw;

   assign prod    = {33'b0, len_ff} * {32'b0, Recip};
   assign qp      = 64'(quot_ff) * 64'(PAGE_BYTES);
   assign pad     = (rem_ff != '0) ? (PageA - 33'(rem_ff)) : 33'd0;
   assign start_w = fixed_ff ? addr_ff : bump_ff;
   assign app_idx = used_ff[IW-1:0];
   assign rd_end  = {1'b0, rd_s_ff} + {1'b0, rd_l_ff};

   always_comb begin
      case (cmd_ff)
         CMD_MAP:   hit_raw = ({1'b0, addr_ff} < rd_end) && (sum_ff > {2'b0, rd_s_ff});
         CMD_UNMAP: hit_raw = (rd_s_ff == addr_ff);
         default:   hit_raw = (addr_ff >= rd_s_ff) && ({1'b0, addr_ff} < rd_end);
      endcase
   end

   always_comb begin
      sts           = '0;
      sts.cmd       = cmd_ff;
      sts.len_zero  = (len_ff == 32'd0);
      sts.full      = (used_ff >= MaxUsed);
      sts.fixed     = fixed_ff;
      sts.used_zero = (used_ff == '0);
      sts.div_last  = div_ph_ff;
      sts.over      = (sum_ff > {2'b0, limit_ff});
      sts.hit       = act_ff[idx_ff] && hit_raw;
      sts.last      = ((UW'(idx_ff) + UW'(1)) >= used_ff);
      sts.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= 32'hFFFF_FFFF;
         bump_ff      <= 32'd0;
         used_ff      <= '0;
         act_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_REGION_BASE: begin
                  bump_ff <= csr_wdata;
               end
               CSR_ADDRESS_LIMIT: limit_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (ctl.load) idx_ff <= '0;
         else if (ctl.idx_inc) idx_ff <= idx_ff + IW'(1);
         if (ctl.finish) begin
            rsp_valid_ff <= 1'b1;
            if (ctl.res == RES_MAPOK) begin
               act_ff[app_idx] <= 1'b1;
               used_ff         <= used_ff + UW'(1);
               if (!fixed_ff) bump_ff <= sum_ff[31:0];
            end else if (ctl.res == RES_HIT && cmd_ff == CMD_UNMAP) begin
               act_ff[idx_ff] <= 1'b0;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // region memories
   always_ff @(posedge clock) begin
      if (ctl.finish && ctl.res == RES_MAPOK) begin
         start_mem[app_idx] <= start_w;
         len_mem[app_idx]   <= alen_ff[31:0];
      end
      if (ctl.finish && ctl.res == RES_MAPOK) begin
         prot_mem[app_idx] <= prot_ff;
      end else if (ctl.finish && ctl.res == RES_HIT && cmd_ff == CMD_PROTECT) begin
         prot_mem[idx_ff] <= prot_ff;
      end
      if (ctl.rd_en) begin
         rd_s_ff <= start_mem[idx_ff];
         rd_l_ff <= len_mem[idx_ff];
         rd_p_ff <= prot_mem[idx_ff];
      end
   end

   // item latch, remainder unit and result payload
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff    <= cmd_type'(req_tuser);
         addr_ff   <= req_tdata[31:0] & ADDR_MASK;
         len_ff    <= req_tdata[63:32];
         prot_ff   <= req_tdata[66:64];
         fixed_ff  <= req_tdata[67];
         wr_ff     <= req_tdata[68];
         rem_ff    <= '0;
         div_ph_ff <= 1'b0;
      end else if (ctl.div_step) begin
         // reciprocal multiply gives the quotient, the next cycle the remainder
         if (!div_ph_ff) quot_ff <= 32'(prod >> (32 + PL));
         else            rem_ff  <= PW'(len_ff - qp[31:0]);
         div_ph_ff <= 1'b1;
      end
      if (ctl.pad) alen_ff <= {1'b0, len_ff} + pad;
      if (ctl.sum) sum_ff <= {2'b0, start_w} + {1'b0, alen_ff};
      if (ctl.finish) begin
         rsp_status_ff <= STS_OK;
         rsp_start_ff  <= 32'd0;
         rsp_inreg_ff  <= 1'b0;
         rsp_allow_ff  <= 1'b0;
         case (ctl.res)
            RES_ZERO:    rsp_status_ff <= STS_ZERO;
            RES_FULL:    rsp_status_ff <= STS_FULL;
            RES_LIMIT:   rsp_status_ff <= STS_LIMIT;
            RES_OVERLAP: rsp_status_ff <= STS_OVERLAP;
            RES_MAPOK:   rsp_start_ff  <= start_w;
            RES_MISS: begin
               if (cmd_ff == CMD_CHECK) rsp_allow_ff  <= 1'b1;
               else                     rsp_status_ff <= STS_NOREGION;
            end
            RES_HIT: begin
               if (cmd_ff == CMD_CHECK) begin
                  rsp_inreg_ff <= 1'b1;
                  rsp_allow_ff <= wr_ff ? rd_p_ff[1] : rd_p_ff[0];
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_allow_ff, rsp_inreg_ff, rsp_start_ff, rsp_status_ff};

endmodule

FILE: hw/rtl/mapped_region_protection_table.sv
// mapped region protection table: map, unmap, protect and check over a region table
// check/unmap/protect: decode, then a scan testing one entry at a time; map: decode, page
// rounding by reciprocal multiply (quotient, then remainder), pad, sum, limit test and, for a fixed
// map, a scan; one word is worked on at a time; the next is taken the cycle after the result is
// registered, and a result still waiting in the output register holds the block in its last step
// synchronous active-high reset: table empty, region base 0, address limit all ones
`timescale 1ns / 1ps

module mapped_region_protection_table #(
   parameter int MAX_REGIONS = mrpt_pkg::MAX_REGIONS_DEF,
   parameter int PAGE_BYTES  = mrpt_pkg::PAGE_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // address[31:0], map_length[63:32], protection[66:64], map_fixed[67], is_write[68]
   input  logic [mrpt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // command[1:0]
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status[2:0], mapped_start[34:3], in_region[35], access_allowed[36]
   output logic [mrpt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_index,
   input  logic [31:0]                        csr_wdata
);
   import mrpt_pkg::*;

   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   mrpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   mrpt_datapath #(
      .MAX_REGIONS (MAX_REGIONS),
      .PAGE_BYTES  (PAGE_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .ctl        (ctl),
      .sts        (sts)
   );

endmodule

FILE: hw/rtl/mrpt_checker.sv
// port-level checker for the mapped region protection table
// bound to the top level; uses mrpt_pkg for field widths and codes
`timescale 1ns / 1ps

module mrpt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [mrpt_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import mrpt_pkg::*;

   // result word held while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed or dropped");

   // one word at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous word in progress");

   // a covered check always reports ok
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |-> rsp_tdata[2:0] == STS_OK)
      else $error("in_region set with error status");

   // a mapped start only comes with ok status
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34:3] != 32'd0 |-> rsp_tdata[2:0] == STS_OK)
      else $error("mapped_start set with error status");

endmodule

bind mapped_region_protection_table mrpt_checker u_mrpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/mapped_region_protection_table_tb.sv
// testbench for the mapped region protection table: random and directed commands
// depends on mrpt_pkg and mapped_region_protection_table; predicts every response word
`timescale 1ns / 1ps

module mapped_region_protection_table_tb;
   import mrpt_pkg::*;

   localparam int NREG = 16;
   localparam int PAGE = 4096;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic       wr_access;
      logic       at_fixed;
      logic [2:0] protection;
      logic [31:0] map_length;
      logic [31:0] address;
      cmd_type    command;
   } req_item;

   typedef struct packed {
      logic        access_allowed;
      logic        in_region;
      logic [31:0] mapped_start;
      status_type  status;
   } rsp_item;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_index = 0;
   logic [31:0] csr_wdata = '0;

   mapped_region_protection_table dut (.*);

   always #5 clock = ~clock;

   // shadow of the region table
   logic [31:0] tbl_start [NREG];
   logic [31:0] tbl_len [NREG];
   logic [2:0] tbl_prot [NREG];
   logic tbl_active [NREG];
   int unsigned tbl_used;
   logic [31:0] bump, limit_reg;

   req_item pending_q[$];
   rsp_item expected_q[$];
   int errors = 0;
   int words_in = 0, words_out = 0;
   bit hold_off = 0;
   int idle_cycles = 0;

   function automatic int covering(logic [31:0] a);
      for (int i = 0; i < tbl_used; i++)
         if (tbl_active[i] && {1'b0, a} >= {1'b0, tbl_start[i]} &&
             {1'b0, a} < {1'b0, tbl_start[i]} + {1'b0, tbl_len[i]})
            return i;
      return -1;
   endfunction

   function automatic rsp_item apply_command(req_item r);
      rsp_item o;
      logic [33:0] alen, pos;
      int k;
      o = '0;
      o.status = STS_OK;
      case (r.command)
         CMD_MAP: begin
            alen = ({2'b0, r.map_length} + PAGE - 1) / PAGE * PAGE;
            pos = r.at_fixed ? {2'b0, r.address} : {2'b0, bump};
            if (r.map_length == 0) o.status = STS_ZERO;
            else if (tbl_used >= NREG) o.status = STS_FULL;
            else if (pos + alen > {2'b0, limit_reg}) o.status = STS_LIMIT;
            else begin
               if (r.at_fixed)
                  for (int i = 0; i < tbl_used; i++)
                     if (tbl_active[i] && pos < {2'b0, tbl_start[i]} + {2'b0, tbl_len[i]} &&
                         pos + alen > {2'b0, tbl_start[i]})
                        o.status = STS_OVERLAP;
               if (o.status == STS_OK) begin
                  if (!r.at_fixed) bump = pos[31:0] + alen[31:0];
                  tbl_start[tbl_used] = pos[31:0];
                  tbl_len[tbl_used] = alen[31:0];
                  tbl_prot[tbl_used] = r.protection;
                  tbl_active[tbl_used] = 1;
                  tbl_used++;
                  o.mapped_start = pos[31:0];
               end
            end
         end
         CMD_UNMAP: begin
            o.status = STS_NOREGION;
            for (int i = 0; i < tbl_used; i++)
               if (o.status != STS_OK && tbl_active[i] && tbl_start[i] == r.address) begin
                  tbl_active[i] = 0;
                  o.status = STS_OK;
               end
         end
         CMD_PROTECT: begin
            k = covering(r.address);
            if (k < 0) o.status = STS_NOREGION;
            else tbl_prot[k] = r.protection;
         end
         default: begin
            k = covering(r.address);
            if (k < 0) o.access_allowed = 1;
            else begin
               o.in_region = 1;
               o.access_allowed = r.wr_access ? tbl_prot[k][1] : tbl_prot[k][0];
            end
         end
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
      $display("mismatch on %s: got %h expected %h", what, got, exp);
      errors++;
   endtask

   // request driver with random gaps
   int gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (req_tvalid && !req_tready) begin
      end else if (gap > 0) begin
         gap <= gap - 1;
         req_tvalid <= 0;
      end else if (pending_q.size() > 0) begin
         req_item r;
         r = pending_q.pop_front();
         expected_q = {expected_q, apply_command(r)};
         req_tdata <= {3'b0, r.wr_access, r.at_fixed, r.protection, r.map_length, r.address};
         req_tuser <= r.command;
         req_tvalid <= 1;
         words_in++;
         gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) :
                ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
      end else begin
         req_tvalid <= 0;
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_item got, exp;
            got = rsp_tdata[36:0];
            words_out++;
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected response word", 32'd0, 32'd0);
            end else begin
               exp = expected_q.pop_front();
               if (got.status != exp.status)
                  report_mismatch("status", 32'(got.status), 32'(exp.status));
               if (got.mapped_start != exp.mapped_start)
                  report_mismatch("mapped_start", got.mapped_start, exp.mapped_start);
               if (got.in_region != exp.in_region)
                  report_mismatch("in_region", 32'(got.in_region), 32'(exp.in_region));
               if (got.access_allowed != exp.access_allowed)
                  report_mismatch("access_allowed", 32'(got.access_allowed),
                                  32'(exp.access_allowed));
            end
         end
         rsp_tready <= hold_off ? 1'b0 :
                       ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (!hold_off)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_REGION_BASE) bump = val;
      else limit_reg = val;
   endtask

   task automatic drain;
      wait (pending_q.size() == 0 && expected_q.size() == 0);
      repeat (120) @(posedge clock);
   endtask

   function automatic req_item make(cmd_type c, logic [31:0] a, logic [31:0] len,
                                    logic [2:0] p, logic f, logic w);
      req_item r;
      r.command = c; r.address = a; r.map_length = len;
      r.protection = p; r.at_fixed = f; r.wr_access = w;
      return r;
   endfunction

   task automatic queue_item(req_item r);
      pending_q = {pending_q, r};
   endtask

   // pick an address near an existing region boundary most of the time
   function automatic logic [31:0] near_addr();
      int i;
      if (tbl_used == 0 || $urandom_range(0, 4) == 0) return $urandom();
      i = $urandom_range(0, tbl_used - 1);
      case ($urandom_range(0, 3))
         0: return tbl_start[i];
         1: return tbl_start[i] + tbl_len[i] - 1;
         2: return tbl_start[i] + tbl_len[i];
         default: return tbl_start[i] + $urandom_range(0, 3 * PAGE);
      endcase
   endfunction

   task automatic random_phase(int n);
      req_item r;
      logic [31:0] len;
      for (int i = 0; i < n; i++) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom() :
               ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 5 * PAGE);
         r = make(cmd_type'($urandom_range(0, 3)), near_addr(), len,
                  3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
         // the shadow moves only as items are driven, so addresses come from a lagging view
         queue_item(r);
         wait (pending_q.size() < 4);
      end
   endtask

   initial begin
      tbl_used = 0;
      bump = 0; limit_reg = 32'hFFFF_FFFF;
      for (int i = 0; i < NREG; i++) begin
         tbl_active[i] = 0; tbl_start[i] = 0; tbl_len[i] = 0; tbl_prot[i] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: every command and extremes
      queue_item(make(CMD_CHECK, 32'h0, 32'h0, 3'd0, 1'b0, 1'b1));
      queue_item(make(CMD_MAP, 32'h0, 32'h0, 3'd7, 1'b0, 1'b0));
      queue_item(make(CMD_MAP, 32'h0, 32'h1, 3'd1, 1'b0, 1'b0));
      queue_item(make(CMD_MAP, 32'hFFFF_F000, 32'h1000, 3'd2, 1'b1, 1'b1));
      queue_item(make(CMD_MAP, 32'hFFFF_E000, 32'h1000, 3'd2, 1'b1, 1'b1));
      queue_item(make(CMD_MAP, 32'h800, 32'h10, 3'd7, 1'b1, 1'b0));
      queue_item(make(CMD_MAP, 32'h0, 32'hFFFF_FFFF, 3'd7, 1'b0, 1'b0));
      queue_item(make(CMD_CHECK, 32'h0FFF, 32'h0, 3'd0, 1'b0, 1'b0));
      queue_item(make(CMD_CHECK, 32'h0FFF, 32'h0, 3'd0, 1'b0, 1'b1));
      queue_item(make(CMD_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1));
      queue_item(make(CMD_PROTECT, 32'h0010, 32'h0, 3'd6, 1'b0, 1'b0));
      queue_item(make(CMD_PROTECT, 32'h8000_0000, 32'h0, 3'd6, 1'b0, 1'b0));
      queue_item(make(CMD_CHECK, 32'h0010, 32'h0, 3'd0, 1'b0, 1'b1));
      queue_item(make(CMD_UNMAP, 32'h0010, 32'h0, 3'd0, 1'b0, 1'b0));
      queue_item(make(CMD_UNMAP, 32'h0, 32'h0, 3'd0, 1'b0, 1'b0));
      queue_item(make(CMD_UNMAP, 32'h0, 32'h0, 3'd0, 1'b0, 1'b0));
      for (int i = 0; i < 8; i++)
         queue_item(make(CMD_MAP, 32'h0, 32'h2000, i[2:0], 1'b0, 1'b0));
      drain();

      // phases with fresh tables are impossible without reset, so vary the registers
      write_csr(CSR_REGION_BASE, 32'h1000_0000);
      write_csr(CSR_ADDRESS_LIMIT, 32'h1002_0000);
      random_phase(150);
      drain();
      write_csr(CSR_ADDRESS_LIMIT, 32'h0);
      random_phase(100);
      drain();
      write_csr(CSR_REGION_BASE, 32'hFFFF_FFFF);
      write_csr(CSR_ADDRESS_LIMIT, 32'hFFFF_FFFF);
      random_phase(150);

      // long receiver hold-off while the sender keeps offering words
      hold_off = 1;
      fork
         random_phase(20);
         begin
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
      join
      drain();
      write_csr(CSR_REGION_BASE, $urandom());
      random_phase(380);
      drain();

      $display("%0d request words driven, %0d responses checked, all commands and csr extremes",
               words_in, words_out);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
